[rtl/pss_pkg.sv]
// ----------------------------------------------------------------------------
// pss_pkg
// Shared types and codes of the positional sequence store: command codes,
// the shift command that runs along the cell row and the mark command.
// ----------------------------------------------------------------------------
package pss_pkg;

  localparam int WORD_W = 32;
  localparam int FUNC_W = 4;
  localparam int POS_W  = 8;
  localparam int OCC_W  = 7;

  localparam logic [WORD_W-1:0] EMPTY_WORD = '1;

  localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 4'd0;
  localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 4'd1;
  localparam logic [FUNC_W-1:0] FN_INSERT_AT  = 4'd2;
  localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 4'd3;
  localparam logic [FUNC_W-1:0] FN_POP_BACK   = 4'd4;
  localparam logic [FUNC_W-1:0] FN_REMOVE_AT  = 4'd5;
  localparam logic [FUNC_W-1:0] FN_READ_AT    = 4'd6;
  localparam logic [FUNC_W-1:0] FN_CONTAINS   = 4'd7;
  localparam logic [FUNC_W-1:0] FN_CLEAR      = 4'd8;

  typedef enum logic [1:0] {
    SH_HOLD   = 2'd0,
    SH_INSERT = 2'd1,
    SH_REMOVE = 2'd2
  } shift_op_t;

  typedef struct packed {
    shift_op_t         op;
    logic [WORD_W-1:0] word;
  } shift_cmd_t;

  typedef struct packed {
    logic              do_read;
    logic              do_find;
    logic [WORD_W-1:0] key;
    logic [POS_W-1:0]  pos;
  } mark_cmd_t;

endpackage

[rtl/pss_cmd_if.sv]
// ----------------------------------------------------------------------------
// pss_cmd_if / pss_res_if
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface pss_cmd_if;
  logic               valid;
  logic               ready;
  logic [3:0]         func;
  logic signed [31:0] value;
  logic [7:0]         position;

  modport source (output valid, func, value, position, input ready);
  modport sink   (input valid, func, value, position, output ready);
endinterface

interface pss_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] read_value;
  logic               found;
  logic signed [31:0] front_value;
  logic signed [31:0] back_value;
  logic [6:0]         occupancy;
  logic               empty_flag;
  logic               dropped;

  modport source (output valid, read_value, found, front_value, back_value,
                  occupancy, empty_flag, dropped, input ready);
  modport sink   (input valid, read_value, found, front_value, back_value,
                  occupancy, empty_flag, dropped, output ready);
endinterface

[rtl/positional_sequence_store.sv]
// ----------------------------------------------------------------------------
// positional_sequence_store
// Ordered store of up to CAPACITY signed words held in a row of shifting
// cells, with push, pop, insert, remove, read, search and clear commands.
//
//   channel   direction  word
//   in_cmd    in         func, value, position
//   out_res   out        read_value, found, front/back_value, occupancy, flags
//
// Each command passes these steps in order: accept and shift of the cell row,
// marking in every cell, a registered merge over groups of eight cells, and
// the load of the output register. The marks and the group merge are
// registered between the accept and the output load.
// Reset empties the store at once; cell contents need no clearing pass.
// A stalled result holds the block in its last step; the next command may be
// accepted while the previous result still waits.
// ----------------------------------------------------------------------------
module positional_sequence_store #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  pss_cmd_if.sink     in_cmd,
  pss_res_if.source   out_res
);
  import pss_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CW    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_MARK  = 4'b0010,
    S_GROUP = 4'b0100,
    S_FINAL = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  mark_cmd_t         mark_r, mark_nxt;
  logic              drop_r, drop_nxt;
  shift_cmd_t        shift;
  logic [IDX_W-1:0]  tgt_idx;
  logic              accept, full, pos_lt, out_load;
  logic [CW-1:0]     pos_ext, cnt_ext;

  logic [WORD_W-1:0] cell_word [CAPACITY];
  logic [CAPACITY-1:0] cell_hit, cell_rsel, cell_fsel;
  logic [WORD_W-1:0] read_word, front_word;
  logic              found;

  logic              out_valid_r;
  logic [WORD_W-1:0] read_value_r, front_value_r, back_value_r;
  logic              found_r, empty_r, dropped_r;
  logic [OCC_W-1:0]  occ_r;

  assign in_cmd.ready = (state_r == S_IDLE);
  assign accept       = in_cmd.valid && in_cmd.ready;
  assign full         = (count_r == CNT_W'(CAPACITY));
  assign pos_ext      = CW'(in_cmd.position);
  assign cnt_ext      = CW'(count_r);
  assign pos_lt       = pos_ext < cnt_ext;

  always_comb begin
    shift.op   = SH_HOLD;
    shift.word = in_cmd.value;
    tgt_idx    = '0;
    count_nxt  = count_r;
    drop_nxt   = drop_r;
    mark_nxt   = mark_r;
    if (accept) begin
      drop_nxt         = 1'b0;
      mark_nxt.do_read = 1'b0;
      mark_nxt.do_find = 1'b0;
      mark_nxt.key     = in_cmd.value;
      mark_nxt.pos     = in_cmd.position;
      unique case (in_cmd.func)
        FN_PUSH_FRONT, FN_PUSH_BACK, FN_INSERT_AT: begin
          if (full) begin
            drop_nxt = 1'b1;
          end else begin
            shift.op  = SH_INSERT;
            count_nxt = count_r + 1'b1;
            if (in_cmd.func == FN_PUSH_FRONT) begin
              tgt_idx = IDX_W'(count_r);
            end else if (in_cmd.func == FN_INSERT_AT) begin
              tgt_idx = pos_lt ? IDX_W'(in_cmd.position) : IDX_W'(count_r);
            end
          end
        end
        FN_POP_FRONT: begin
          if (count_r != '0) count_nxt = count_r - 1'b1;
        end
        FN_POP_BACK: begin
          if (count_r != '0) begin
            shift.op  = SH_REMOVE;
            count_nxt = count_r - 1'b1;
          end
        end
        FN_REMOVE_AT: begin
          if (count_r != '0) begin
            shift.op  = SH_REMOVE;
            count_nxt = count_r - 1'b1;
            tgt_idx   = pos_lt ? IDX_W'(in_cmd.position) : IDX_W'(count_r - 1'b1);
          end
        end
        FN_READ_AT:  mark_nxt.do_read = 1'b1;
        FN_CONTAINS: mark_nxt.do_find = 1'b1;
        FN_CLEAR:    count_nxt = '0;
        default: ;
      endcase
    end
  end

  // Output register is free when empty or being drained this cycle.
  assign out_load = (state_r == S_FINAL) && (!out_valid_r || out_res.ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = S_MARK;
      S_MARK:  state_nxt = S_GROUP;
      S_GROUP: state_nxt = S_FINAL;
      S_FINAL: if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    mark_r <= mark_nxt;
    drop_r <= drop_nxt;
    if (out_load) begin
      read_value_r  <= read_word;
      found_r       <= found;
      front_value_r <= (count_r == '0) ? EMPTY_WORD : front_word;
      back_value_r  <= (count_r == '0) ? EMPTY_WORD : cell_word[0];
      occ_r         <= OCC_W'(count_r);
      empty_r       <= (count_r == '0);
      dropped_r     <= drop_r;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WORD_W-1:0] below_w, above_w;
    if (i == 0) begin : g_first
      assign below_w = '0;
    end else begin : g_mid_lo
      assign below_w = cell_word[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign above_w = '0;
    end else begin : g_mid_hi
      assign above_w = cell_word[i+1];
    end
    pss_cell #(
      .IDX   (i),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk     (clk),
      .shift   (shift),
      .tgt_idx (tgt_idx),
      .below   (below_w),
      .above   (above_w),
      .mark_en (state_r == S_MARK),
      .mark    (mark_r),
      .count   (count_r),
      .word    (cell_word[i]),
      .hit     (cell_hit[i]),
      .rsel    (cell_rsel[i]),
      .fsel    (cell_fsel[i])
    );
  end

  pss_gather #(
    .CAPACITY (CAPACITY)
  ) u_gather (
    .clk        (clk),
    .load       (state_r == S_GROUP),
    .hit        (cell_hit),
    .rsel       (cell_rsel),
    .fsel       (cell_fsel),
    .words      (cell_word),
    .read_word  (read_word),
    .front_word (front_word),
    .found      (found)
  );

  assign out_res.valid       = out_valid_r;
  assign out_res.read_value  = read_value_r;
  assign out_res.found       = found_r;
  assign out_res.front_value = front_value_r;
  assign out_res.back_value  = back_value_r;
  assign out_res.occupancy   = occ_r;
  assign out_res.empty_flag  = empty_r;
  assign out_res.dropped     = dropped_r;
endmodule

[rtl/pss_cell.sv]
// ----------------------------------------------------------------------------
// pss_cell
// One storage cell of the row. Holds one word, takes the word of a neighbor
// on insert or remove, and registers its match and select marks.
// ----------------------------------------------------------------------------
module pss_cell #(
  parameter int IDX   = 0,
  parameter int IDX_W = 6,
  parameter int CNT_W = 7
) (
  input  logic                     clk,
  input  pss_pkg::shift_cmd_t      shift,
  input  logic [IDX_W-1:0]         tgt_idx,
  input  logic [pss_pkg::WORD_W-1:0] below,
  input  logic [pss_pkg::WORD_W-1:0] above,
  input  logic                     mark_en,
  input  pss_pkg::mark_cmd_t       mark,
  input  logic [CNT_W-1:0]         count,
  output logic [pss_pkg::WORD_W-1:0] word,
  output logic                     hit,
  output logic                     rsel,
  output logic                     fsel
);
  import pss_pkg::*;

  localparam int PW = (IDX_W > POS_W) ? IDX_W : POS_W;
  localparam logic [IDX_W-1:0] ME = IDX_W'(IDX);

  logic [WORD_W-1:0] word_r, word_nxt;
  logic              hit_r, rsel_r, fsel_r;
  logic              in_use;

  always_comb begin
    word_nxt = word_r;
    unique case (shift.op)
      SH_INSERT: begin
        if (ME > tgt_idx) begin
          word_nxt = below;
        end else if (ME == tgt_idx) begin
          word_nxt = shift.word;
        end
      end
      SH_REMOVE: begin
        if (ME >= tgt_idx) begin
          word_nxt = above;
        end
      end
      default: word_nxt = word_r;
    endcase
  end

  assign in_use = CNT_W'(IDX) < count;

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    if (mark_en) begin
      hit_r  <= mark.do_find && in_use && (word_r == mark.key);
      rsel_r <= mark.do_read && in_use && (PW'(mark.pos) == PW'(IDX));
      fsel_r <= (count == CNT_W'(IDX + 1));
    end
  end

  assign word = word_r;
  assign hit  = hit_r;
  assign rsel = rsel_r;
  assign fsel = fsel_r;
endmodule

[rtl/pss_gather.sv]
// ----------------------------------------------------------------------------
// pss_gather
// Collects the marked words of the row: a registered stage over groups of
// eight cells, then a combinational merge of the group results.
// ----------------------------------------------------------------------------
module pss_gather #(
  parameter int CAPACITY = 64
) (
  input  logic                       clk,
  input  logic                       load,
  input  logic [CAPACITY-1:0]        hit,
  input  logic [CAPACITY-1:0]        rsel,
  input  logic [CAPACITY-1:0]        fsel,
  input  logic [pss_pkg::WORD_W-1:0] words [CAPACITY],
  output logic [pss_pkg::WORD_W-1:0] read_word,
  output logic [pss_pkg::WORD_W-1:0] front_word,
  output logic                       found
);
  import pss_pkg::*;

  localparam int GRP  = 8;
  localparam int NGRP = (CAPACITY + GRP - 1) / GRP;

  logic [WORD_W-1:0] grp_read_r [NGRP];
  logic [WORD_W-1:0] grp_front_r[NGRP];
  logic [NGRP-1:0]   grp_hit_r;
  logic [WORD_W-1:0] grp_read_nxt [NGRP];
  logic [WORD_W-1:0] grp_front_nxt[NGRP];
  logic [NGRP-1:0]   grp_hit_nxt;

  // At most one cell is selected for read and one for front, so an
  // AND-OR merge is enough.
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_read_nxt[g]  = '0;
      grp_front_nxt[g] = '0;
      grp_hit_nxt[g]   = 1'b0;
      for (int j = 0; j < GRP; j++) begin
        if (g * GRP + j < CAPACITY) begin
          grp_read_nxt[g]  = grp_read_nxt[g]
                             | (words[g*GRP+j] & {WORD_W{rsel[g*GRP+j]}});
          grp_front_nxt[g] = grp_front_nxt[g]
                             | (words[g*GRP+j] & {WORD_W{fsel[g*GRP+j]}});
          grp_hit_nxt[g]   = grp_hit_nxt[g] | hit[g*GRP+j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp_read_r  <= grp_read_nxt;
      grp_front_r <= grp_front_nxt;
      grp_hit_r   <= grp_hit_nxt;
    end
  end

  always_comb begin
    read_word  = '0;
    front_word = '0;
    for (int g = 0; g < NGRP; g++) begin
      read_word  = read_word | grp_read_r[g];
      front_word = front_word | grp_front_r[g];
    end
  end

  assign found = |grp_hit_r;
endmodule

[rtl/pss_chk.sv]
// ----------------------------------------------------------------------------
// pss_chk
// Port-level checks of the positional sequence store, bound to the top level.
// ----------------------------------------------------------------------------
module pss_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_read_value,
  input logic [31:0] out_front_value,
  input logic [31:0] out_back_value,
  input logic [6:0]  out_occupancy,
  input logic        out_empty_flag
);

  // A stalled result word holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_value)
      && $stable(out_front_value) && $stable(out_occupancy))
    else $error("stalled result changed");

  // Commands are taken one at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("command accepted while busy");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_flag |-> out_occupancy == 7'd0)
    else $error("empty store reports words");

  a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_flag |-> out_front_value == 32'hFFFF_FFFF
      && out_back_value == 32'hFFFF_FFFF)
    else $error("empty store reports front or back word");

endmodule

bind positional_sequence_store pss_chk u_pss_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_cmd.valid),
  .in_ready        (in_cmd.ready),
  .out_valid       (out_res.valid),
  .out_ready       (out_res.ready),
  .out_read_value  (out_res.read_value),
  .out_front_value (out_res.front_value),
  .out_back_value  (out_res.back_value),
  .out_occupancy   (out_res.occupancy),
  .out_empty_flag  (out_res.empty_flag)
);

[dv/positional_sequence_store_tb.sv]
// ----------------------------------------------------------------------------
// positional_sequence_store_tb
// Self-checking bench for the positional sequence store. A table of
// directed commands covers the empty store, the edge words, the clamped
// indexes and the unused command codes. Random phases then fill, drain and
// churn the store with random idling on both channels. Every result word is
// compared field by field against its typed row or an in-bench model of the sequence.
// ----------------------------------------------------------------------------
module positional_sequence_store_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pss_pkg::*;

  localparam int          CAPACITY     = 64;
  localparam int          CLK_HALF     = 5;
  localparam int          RANDOM_ITEMS = 750;
  localparam int          HOLD_AT      = 200;
  localparam int          PAUSE_AT     = 450;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          IDLE_LIMIT   = 4000;
  localparam int          SETTLE       = 8;
  localparam int          MAX_PRINTS   = 40;

  localparam logic [FUNC_W-1:0] FN_RESERVED_FIRST = 4'd9;
  localparam logic [FUNC_W-1:0] FN_RESERVED_LAST  = 4'd15;

  typedef enum logic [1:0] {
    PH_FILL  = 2'd0,
    PH_MIX   = 2'd1,
    PH_DRAIN = 2'd2
  } phase_t;

  typedef struct packed {
    logic [WORD_W-1:0] read_value;
    logic              found;
    logic [WORD_W-1:0] front_value;
    logic [WORD_W-1:0] back_value;
    logic [OCC_W-1:0]  occupancy;
    logic              empty_flag;
    logic              dropped;
  } status_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [WORD_W-1:0] value;
    logic [POS_W-1:0]  position;
    logic              typed;
    status_t           want;
  } stim_row_t;

  localparam status_t NO_STATUS    = '0;
  localparam status_t EMPTY_STATUS = '{32'd0, 1'b0, EMPTY_WORD, EMPTY_WORD, 7'd0, 1'b1, 1'b0};

  localparam logic [WORD_W-1:0] EDGE_WORDS [4] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF
  };

  // Rows with typed results need nothing but the reset state and the rows up
  // to and including them; the others are left to the sequence model.
  localparam stim_row_t DIRECTED_ROWS [25] = '{
    '{FN_POP_FRONT,      32'h0000_0000, 8'd0,   1'b1, EMPTY_STATUS},
    '{FN_POP_BACK,       32'h0000_0000, 8'd0,   1'b1, EMPTY_STATUS},
    '{FN_REMOVE_AT,      32'h0000_0000, 8'd255, 1'b1, EMPTY_STATUS},
    '{FN_READ_AT,        32'h0000_0000, 8'd0,   1'b1, EMPTY_STATUS},
    '{FN_CONTAINS,       32'h0000_0000, 8'd0,   1'b1, EMPTY_STATUS},
    '{FN_CLEAR,          32'h0000_0000, 8'd0,   1'b1, EMPTY_STATUS},
    '{FN_PUSH_FRONT,     32'h7FFF_FFFF, 8'd0,   1'b1,
      '{32'd0, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 7'd1, 1'b0, 1'b0}},
    '{FN_PUSH_BACK,      32'h8000_0000, 8'd255, 1'b1,
      '{32'd0, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 7'd2, 1'b0, 1'b0}},
    '{FN_INSERT_AT,      32'h0000_0000, 8'd255, 1'b0, NO_STATUS},
    '{FN_INSERT_AT,      32'hFFFF_FFFF, 8'd0,   1'b0, NO_STATUS},
    '{FN_INSERT_AT,      32'h0000_5A5A, 8'd2,   1'b0, NO_STATUS},
    '{FN_READ_AT,        32'h0000_0000, 8'd0,   1'b0, NO_STATUS},
    '{FN_READ_AT,        32'h0000_0000, 8'd4,   1'b0, NO_STATUS},
    '{FN_READ_AT,        32'h0000_0000, 8'd5,   1'b0, NO_STATUS},
    '{FN_READ_AT,        32'h0000_0000, 8'd255, 1'b0, NO_STATUS},
    '{FN_CONTAINS,       32'h8000_0000, 8'd0,   1'b0, NO_STATUS},
    '{FN_CONTAINS,       32'h1234_5678, 8'd0,   1'b0, NO_STATUS},
    '{FN_REMOVE_AT,      32'h0000_0000, 8'd255, 1'b0, NO_STATUS},
    '{FN_REMOVE_AT,      32'h0000_0000, 8'd1,   1'b0, NO_STATUS},
    '{FN_POP_FRONT,      32'h0000_0000, 8'd0,   1'b0, NO_STATUS},
    '{FN_POP_BACK,       32'h0000_0000, 8'd0,   1'b0, NO_STATUS},
    '{FN_RESERVED_FIRST, 32'hAAAA_AAAA, 8'hAA,  1'b0, NO_STATUS},
    '{FN_RESERVED_LAST,  32'h5555_5555, 8'h55,  1'b0, NO_STATUS},
    '{FN_CLEAR,          32'h0000_0000, 8'd0,   1'b1, EMPTY_STATUS},
    '{FN_INSERT_AT,      32'h0000_0005, 8'd200, 1'b1,
      '{32'd0, 1'b0, 32'd5, 32'd5, 7'd1, 1'b0, 1'b0}}
  };

  logic clk = 1'b0;
  logic rst_n;

  pss_cmd_if cmd_bus ();
  pss_res_if res_bus ();

  positional_sequence_store #(
    .CAPACITY (CAPACITY)
  ) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_cmd  (cmd_bus),
    .out_res (res_bus)
  );

  always #CLK_HALF clk = ~clk;

  // Model of the stored sequence; index 0 is the back.
  logic [WORD_W-1:0] seq_cells [CAPACITY];
  int unsigned       seq_len = 0;

  status_t     status_queue [$];
  int unsigned sender_mode   = 0;
  bit          hold_request  = 1'b0;
  int unsigned error_count   = 0;
  int unsigned checked_count = 0;
  int unsigned issued_count  = 0;
  int unsigned drop_count    = 0;
  int unsigned hit_count     = 0;
  int unsigned peak_len      = 0;
  int unsigned idle_cycles   = 0;

  function automatic void drop_cell(int unsigned idx);
    int unsigned i;
    for (i = idx; i + 1 < seq_len; i++) seq_cells[i] = seq_cells[i + 1];
    seq_len--;
  endfunction

  function automatic status_t advance_sequence(logic [FUNC_W-1:0] f,
                                               logic [WORD_W-1:0] v,
                                               logic [POS_W-1:0] p);
    status_t     st;
    int unsigned slot;
    int unsigned i;
    st = '0;
    case (f)
      FN_PUSH_FRONT, FN_PUSH_BACK, FN_INSERT_AT: begin
        if (seq_len >= CAPACITY) begin
          st.dropped = 1'b1;
        end else begin
          if (f == FN_PUSH_FRONT) slot = seq_len;
          else if (f == FN_PUSH_BACK) slot = 0;
          else slot = (p < seq_len) ? p : seq_len;
          for (i = seq_len; i > slot; i--) seq_cells[i] = seq_cells[i - 1];
          seq_cells[slot] = v;
          seq_len++;
        end
      end
      FN_POP_FRONT: begin
        // The front is the top index, so nothing has to move.
        if (seq_len > 0) seq_len--;
      end
      FN_POP_BACK: begin
        if (seq_len > 0) drop_cell(0);
      end
      FN_REMOVE_AT: begin
        if (seq_len > 0) drop_cell((p < seq_len) ? p : seq_len - 1);
      end
      FN_READ_AT: begin
        if (p < seq_len) st.read_value = seq_cells[p];
      end
      FN_CONTAINS: begin
        for (i = 0; i < seq_len; i++) if (seq_cells[i] == v) st.found = 1'b1;
      end
      FN_CLEAR: begin
        seq_len = 0;
      end
      default: begin
      end
    endcase
    st.front_value = (seq_len > 0) ? seq_cells[seq_len - 1] : EMPTY_WORD;
    st.back_value  = (seq_len > 0) ? seq_cells[0] : EMPTY_WORD;
    st.occupancy   = OCC_W'(seq_len);
    st.empty_flag  = (seq_len == 0);
    return st;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (error_count < MAX_PRINTS)
      $display("[%0t] MISMATCH on result %0d, %s: got %0d, expected %0d",
               $realtime, checked_count, what, got, want);
    error_count++;
  endtask

  // Called at a falling edge; returns at a falling edge after the word has
  // been taken and any idle gap has passed.
  task automatic issue_command(input logic [FUNC_W-1:0] f, input logic [WORD_W-1:0] v,
                               input logic [POS_W-1:0] p, input logic typed,
                               input status_t want);
    status_t     st;
    int unsigned gap;
    int unsigned r;
    cmd_bus.valid    <= 1'b1;
    cmd_bus.func     <= f;
    cmd_bus.value    <= v;
    cmd_bus.position <= p;
    @(posedge clk);
    while (!cmd_bus.ready) @(posedge clk);
    st = advance_sequence(f, v, p);
    status_queue.push_back(typed ? want : st);
    issued_count++;
    if (st.dropped) drop_count++;
    if (st.found) hit_count++;
    if (seq_len > peak_len) peak_len = seq_len;
    @(negedge clk);
    r   = $urandom_range(0, 99);
    gap = 0;
    if (sender_mode == 1) begin
      if (r >= 96) gap = $urandom_range(10, 40);
      else if (r >= 75) gap = $urandom_range(1, 3);
    end else if (sender_mode == 2) begin
      if (r >= 92) gap = $urandom_range(15, 60);
      else if (r >= 45) gap = $urandom_range(1, 5);
    end
    if (gap != 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Result checker.
  always @(posedge clk) begin
    status_t want;
    if (rst_n && res_bus.valid && res_bus.ready) begin
      if (status_queue.size() == 0) begin
        report_mismatch("result word with nothing outstanding", 1, 0);
      end else begin
        want = status_queue.pop_front();
        if (res_bus.read_value !== want.read_value)
          report_mismatch("read_value", res_bus.read_value, $signed(want.read_value));
        if (res_bus.found !== want.found)
          report_mismatch("found", res_bus.found, want.found);
        if (res_bus.front_value !== want.front_value)
          report_mismatch("front_value", res_bus.front_value, $signed(want.front_value));
        if (res_bus.back_value !== want.back_value)
          report_mismatch("back_value", res_bus.back_value, $signed(want.back_value));
        if (res_bus.occupancy !== want.occupancy)
          report_mismatch("occupancy", res_bus.occupancy, want.occupancy);
        if (res_bus.empty_flag !== want.empty_flag)
          report_mismatch("empty_flag", res_bus.empty_flag, want.empty_flag);
        if (res_bus.dropped !== want.dropped)
          report_mismatch("dropped", res_bus.dropped, want.dropped);
      end
      checked_count++;
    end
  end

  // Watchdog: ends the run when neither channel moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[%0t] Watchdog: no word moved for %0d cycles, %0d results outstanding",
                 $realtime, IDLE_LIMIT, status_queue.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold when asked for.
  initial begin : result_sink
    int unsigned sink_mode;
    int unsigned burst_left;
    int unsigned mode_left;
    int unsigned r;
    sink_mode  = 0;
    burst_left = 0;
    mode_left  = 0;
    res_bus.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        res_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end else begin
        if (mode_left == 0) begin
          sink_mode = $urandom_range(0, 2);
          mode_left = $urandom_range(30, 120);
        end
        mode_left--;
        r = $urandom_range(0, 99);
        if (burst_left != 0) begin
          burst_left--;
          res_bus.ready <= 1'b0;
        end else if (sink_mode == 0) begin
          res_bus.ready <= 1'b1;
        end else if (r < ((sink_mode == 1) ? 80 : 50)) begin
          res_bus.ready <= 1'b1;
        end else if (r < 97) begin
          res_bus.ready <= 1'b0;
        end else begin
          burst_left = $urandom_range(8, 40);
          res_bus.ready <= 1'b0;
        end
      end
    end
  end

  initial begin : command_source
    phase_t            phase;
    int unsigned       phase_left;
    int unsigned       grow_pct;
    int unsigned       shrink_pct;
    int unsigned       n;
    int unsigned       r;
    logic [FUNC_W-1:0] f;
    logic [WORD_W-1:0] v;
    logic [POS_W-1:0]  p;
    cmd_bus.valid    = 1'b0;
    cmd_bus.func     = FN_READ_AT;
    cmd_bus.value    = '0;
    cmd_bus.position = '0;
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    sender_mode = 1;
    foreach (DIRECTED_ROWS[k])
      issue_command(DIRECTED_ROWS[k].func, DIRECTED_ROWS[k].value,
                    DIRECTED_ROWS[k].position, DIRECTED_ROWS[k].typed,
                    DIRECTED_ROWS[k].want);

    // The first phase is long enough to run the store into its full state.
    phase      = PH_FILL;
    phase_left = 120;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        case (phase)
          PH_FILL:  phase = PH_MIX;
          PH_MIX:   phase = ($urandom_range(0, 1) != 0) ? PH_DRAIN : PH_FILL;
          default:  phase = PH_MIX;
        endcase
        phase_left  = $urandom_range(40, 110);
        sender_mode = $urandom_range(0, 2);
      end
      phase_left--;

      if (n == HOLD_AT) hold_request = 1'b1;
      if (n == PAUSE_AT) begin
        cmd_bus.valid <= 1'b0;
        do @(negedge clk); while (status_queue.size() != 0);
      end

      case (phase)
        PH_FILL:  begin grow_pct = 75; shrink_pct = 10; end
        PH_DRAIN: begin grow_pct = 10; shrink_pct = 70; end
        default:  begin grow_pct = 40; shrink_pct = 35; end
      endcase

      r = $urandom_range(0, 99);
      if (r < grow_pct) begin
        case ($urandom_range(0, 2))
          0:       f = FN_PUSH_FRONT;
          1:       f = FN_PUSH_BACK;
          default: f = FN_INSERT_AT;
        endcase
      end else if (r < grow_pct + shrink_pct) begin
        case ($urandom_range(0, 2))
          0:       f = FN_POP_FRONT;
          1:       f = FN_POP_BACK;
          default: f = FN_REMOVE_AT;
        endcase
      end else if (r < 96) begin
        f = ($urandom_range(0, 1) != 0) ? FN_READ_AT : FN_CONTAINS;
      end else if (r == 96 && phase != PH_FILL) begin
        f = FN_CLEAR;
      end else begin
        f = FUNC_W'($urandom_range(FN_RESERVED_FIRST, FN_RESERVED_LAST));
      end

      // Stored words are reused often so that searches hit and duplicates
      // appear in the sequence.
      r = $urandom_range(0, 9);
      if (r < 4) v = $urandom;
      else if (r < 6) v = ($urandom_range(0, 1) != 0) ? WORD_W'($urandom_range(0, 15))
                                                       : -WORD_W'($urandom_range(1, 16));
      else if (r == 6 || seq_len == 0) v = EDGE_WORDS[$urandom_range(0, 3)];
      else v = seq_cells[$urandom_range(0, seq_len - 1)];

      r = $urandom_range(0, 9);
      if (r < 7) p = POS_W'($urandom_range(0, seq_len));
      else if (r < 9) p = POS_W'($urandom_range(0, 255));
      else p = (seq_len == 0) ? '0 : POS_W'(seq_len - 1);

      issue_command(f, v, p, 1'b0, NO_STATUS);
    end

    cmd_bus.valid <= 1'b0;
    while (status_queue.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (status_queue.size() != 0)
      report_mismatch("results never returned", status_queue.size(), 0);

    $display("Sent %0d commands (%0d from the table) through fill, drain and mixed phases.",
             issued_count, $size(DIRECTED_ROWS));
    $display("Peak occupancy %0d of %0d, %0d refused pushes, %0d search hits,",
             peak_len, CAPACITY, drop_count, hit_count);
    $display("%0d results checked, %0d mismatches.", checked_count, error_count);
    if (error_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
